// ----- rtl/i2cms_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master sub-address sequencer:
// request and bus command codes, control codes and the buffer geometry.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Transfer buffer geometry
  localparam int BUF_DEPTH = 64;
  localparam int BUF_IDX_W = $clog2(BUF_DEPTH);
  localparam int BANK_ROWS = BUF_DEPTH / 2;
  localparam int ROW_W     = BUF_IDX_W - 1;

  // Sub-address value that skips the sub-address phase
  localparam logic [7:0] NO_SUBADDR  = 8'hFF;
  // Position value meaning the sub-address byte goes out next
  localparam logic [7:0] POS_SUBADDR = 8'hFF;

  // Request kinds
  typedef enum logic [2:0] {
    FUNC_LOAD       = 3'd0,
    FUNC_BEGIN_WR   = 3'd1,
    FUNC_BEGIN_RD   = 3'd2,
    FUNC_STATUS_EVT = 3'd3,
    FUNC_ERROR_EVT  = 3'd4,
    FUNC_READ_BACK  = 3'd5
  } func_t;

  // Bus commands to the peripheral
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_ADDR_RX = 3'd3,
    CMD_ADDR_TX = 3'd4,
    CMD_DATA_WR = 3'd5
  } cmd_t;

  // Keep / enable / disable control
  typedef enum logic [1:0] {
    CTL_KEEP    = 2'd0,
    CTL_ENABLE  = 2'd1,
    CTL_DISABLE = 2'd2
  } ctl_t;

  // One request item
  typedef struct packed {
    logic [2:0] func;
    logic [6:0] dev_addr;
    logic [7:0] sub_reg;
    logic [6:0] length;
    logic [5:0] index;
    logic [7:0] byte_value;
    logic [4:0] status_flags;
    logic [7:0] rx_first;
    logic [7:0] rx_second;
    logic [3:0] err_flags;
    logic       start_pending;
    logic       stop_pending;
  } req_t;

  // One action result, without the buffer bytes read from memory
  typedef struct packed {
    cmd_t       bus_command;
    logic [7:0] out_byte;
    ctl_t       ack_control;
    logic       ack_next_position;
    ctl_t       buffer_irq;
    ctl_t       irqs_control;
    logic       busy_res;
    logic       error;
    logic       done_res;
    logic       accepted;
  } res_t;

endpackage

// ----- rtl/i2c_master_subaddress_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_master_subaddress_sequencer
// Event-driven I2C master sequencer for register transfers: address,
// optional sub-address, then N data bytes written or read back with a
// repeated start. Holds the transfer buffer in two banked memories.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  in_      slave      in_tvalid / in_tready  in_tuser: func, in_tdata: fields
//  out_     master     out_tvalid / out_tready out_tdata: action result
//
//  From acceptance to result each item passes the input register, then the
//  result register; one item per cycle is sustained while out is not stalled.
//  The buffer sits in two banks (even / odd positions) so that a byte-done
//  read event can store both received bytes together.
//  Reset clears the sequencer flags; buffer contents stay undefined.
//  A stalled result holds both registers; the input side stalls with it.
//
module i2c_master_subaddress_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [6:0] dev_addr, [14:7] sub_reg, [21:15] length, [27:22] index,
  // [35:28] byte_value, [40:36] status_flags, [48:41] rx_first,
  // [56:49] rx_second, [60:57] err_flags, [61] start_pending,
  // [62] stop_pending, [63] zero
  input  logic [63:0] in_tdata,
  // [2:0] func
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] bus_command, [10:3] out_byte, [12:11] ack_control,
  // [13] ack_next_position, [15:14] buffer_irq, [17:16] irqs_control,
  // [18] busy_res, [19] error, [20] done_res, [21] accepted,
  // [29:22] read_data, [31:30] zero
  output logic [31:0] out_tdata
);

  localparam int IW = i2cms_pkg::BUF_IDX_W;
  localparam int RW = i2cms_pkg::ROW_W;

  // Input register
  logic               in_valid_r;
  i2cms_pkg::req_t    req_r;

  // Sequencer state
  logic [7:0] addr_byte_r,    addr_byte_nxt;
  logic [7:0] sub_register_r, sub_register_nxt;
  logic [6:0] byte_count_r,   byte_count_nxt;
  logic       is_reading_r,   is_reading_nxt;
  logic       is_writing_r,   is_writing_nxt;
  logic       busy_r,         busy_nxt;
  logic       error_r,        error_nxt;
  logic       subaddr_done_r, subaddr_done_nxt;
  logic       final_stop_r,   final_stop_nxt;
  logic [7:0] position_r,     position_nxt;
  logic       irqs_en_r,      irqs_en_nxt;

  // Result register
  logic               out_valid_r;
  i2cms_pkg::res_t    res_r,  res_nxt;
  logic               ob_mem_r,  ob_mem_nxt;
  logic               rd_mem_r,  rd_mem_nxt;
  logic               bank_r,    bank_nxt;

  // Buffer banks
  logic [7:0] bank0_mem [i2cms_pkg::BANK_ROWS];
  logic [7:0] bank1_mem [i2cms_pkg::BANK_ROWS];
  logic [7:0] bank0_q_r, bank1_q_r;

  // Write requests (at most two, always to different banks) and read request
  logic          wa_en, wb_en;
  logic [IW-1:0] wa_addr, wb_addr;
  logic [7:0]    wa_data, wb_data;
  logic [IW-1:0] rd_addr;
  logic          we0, we1;
  logic [RW-1:0] wrow0, wrow1;
  logic [7:0]    wdat0, wdat1;

  logic advance;
  logic fire;
  logic [7:0] rd_byte;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = advance && in_valid_r;
  assign in_tready = !in_valid_r || advance;

  // Sign-extend a position to compare against counts
  function automatic logic signed [9:0] pos_sx(input logic [7:0] p);
    pos_sx = $signed({{2{p[7]}}, p});
  endfunction

  // Position lies inside the buffer
  function automatic logic pos_in(input logic [7:0] p);
    pos_in = ({1'b0, p} < 9'(i2cms_pkg::BUF_DEPTH));
  endfunction

  // Capture input items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r.func          <= in_tuser;
      req_r.dev_addr      <= in_tdata[6:0];
      req_r.sub_reg       <= in_tdata[14:7];
      req_r.length        <= in_tdata[21:15];
      req_r.index         <= in_tdata[27:22];
      req_r.byte_value    <= in_tdata[35:28];
      req_r.status_flags  <= in_tdata[40:36];
      req_r.rx_first      <= in_tdata[48:41];
      req_r.rx_second     <= in_tdata[56:49];
      req_r.err_flags     <= in_tdata[60:57];
      req_r.start_pending <= in_tdata[61];
      req_r.stop_pending  <= in_tdata[62];
    end
  end

  // Step the sequencer for one item
  always_comb begin
    logic          rd_phase;
    logic [7:0]    p;
    logic signed [9:0] bc;
    addr_byte_nxt    = addr_byte_r;
    sub_register_nxt = sub_register_r;
    byte_count_nxt   = byte_count_r;
    is_reading_nxt   = is_reading_r;
    is_writing_nxt   = is_writing_r;
    busy_nxt         = busy_r;
    error_nxt        = error_r;
    subaddr_done_nxt = subaddr_done_r;
    final_stop_nxt   = final_stop_r;
    position_nxt     = position_r;
    irqs_en_nxt      = irqs_en_r;

    res_nxt          = '0;
    ob_mem_nxt       = 1'b0;
    rd_mem_nxt       = 1'b0;
    wa_en            = 1'b0;
    wb_en            = 1'b0;
    wa_addr          = '0;
    wb_addr          = '0;
    wa_data          = '0;
    wb_data          = '0;
    rd_addr          = req_r.index;

    rd_phase = is_reading_r && subaddr_done_r;
    bc       = $signed({3'b000, byte_count_r});
    p        = position_r;

    case (req_r.func)
      i2cms_pkg::FUNC_LOAD: begin
        wa_en   = 1'b1;
        wa_addr = req_r.index;
        wa_data = req_r.byte_value;
      end
      i2cms_pkg::FUNC_READ_BACK: begin
        rd_mem_nxt = 1'b1;
        rd_addr    = req_r.index;
      end
      i2cms_pkg::FUNC_BEGIN_WR, i2cms_pkg::FUNC_BEGIN_RD: begin
        if (!busy_r && ({1'b0, req_r.length} <= 8'(i2cms_pkg::BUF_DEPTH))) begin
          res_nxt.accepted = 1'b1;
          addr_byte_nxt    = {req_r.dev_addr, 1'b0};
          sub_register_nxt = req_r.sub_reg;
          is_writing_nxt   = (req_r.func == i2cms_pkg::FUNC_BEGIN_WR);
          is_reading_nxt   = (req_r.func == i2cms_pkg::FUNC_BEGIN_RD);
          byte_count_nxt   = req_r.length;
          busy_nxt         = 1'b1;
          error_nxt        = 1'b0;
          if (!irqs_en_r) begin
            if (!req_r.start_pending) begin
              if (req_r.func == i2cms_pkg::FUNC_BEGIN_RD) begin
                res_nxt.ack_control = i2cms_pkg::CTL_ENABLE;
                res_nxt.ack_next_position = (req_r.length == 7'd2);
              end
              res_nxt.bus_command = i2cms_pkg::CMD_START;
            end
            res_nxt.irqs_control = i2cms_pkg::CTL_ENABLE;
            irqs_en_nxt          = 1'b1;
          end
        end
      end
      i2cms_pkg::FUNC_ERROR_EVT: begin
        if (req_r.err_flags != 4'd0) begin
          error_nxt = 1'b1;
        end
        if (req_r.err_flags[2:0] != 3'd0) begin
          res_nxt.buffer_irq = i2cms_pkg::CTL_DISABLE;
          if (!req_r.err_flags[1] && !req_r.stop_pending) begin
            res_nxt.bus_command  = i2cms_pkg::CMD_STOP;
            res_nxt.irqs_control = i2cms_pkg::CTL_DISABLE;
            irqs_en_nxt          = 1'b0;
          end
        end
        busy_nxt = 1'b0;
      end
      i2cms_pkg::FUNC_STATUS_EVT: begin
        if (req_r.status_flags[0]) begin
          // Start sent: address phase
          p = 8'd0;
          if (is_reading_r &&
              (subaddr_done_r || sub_register_r == i2cms_pkg::NO_SUBADDR)) begin
            subaddr_done_nxt    = 1'b1;
            res_nxt.bus_command = i2cms_pkg::CMD_ADDR_RX;
            res_nxt.out_byte    = addr_byte_r | 8'h01;
          end else begin
            res_nxt.bus_command = i2cms_pkg::CMD_ADDR_TX;
            res_nxt.out_byte    = addr_byte_r;
            if (sub_register_r != i2cms_pkg::NO_SUBADDR) begin
              p = i2cms_pkg::POS_SUBADDR;
            end
          end
        end else if (req_r.status_flags[1]) begin
          // Address sent: set up ACK and buffer interrupt
          if (byte_count_r == 7'd1 && rd_phase) begin
            res_nxt.ack_control = i2cms_pkg::CTL_DISABLE;
            res_nxt.bus_command = i2cms_pkg::CMD_STOP;
            final_stop_nxt      = 1'b1;
            res_nxt.buffer_irq  = i2cms_pkg::CTL_ENABLE;
          end else if (byte_count_r == 7'd2 && rd_phase) begin
            res_nxt.ack_control = i2cms_pkg::CTL_DISABLE;
            res_nxt.buffer_irq  = i2cms_pkg::CTL_DISABLE;
          end else if (byte_count_r == 7'd3 && rd_phase) begin
            res_nxt.buffer_irq  = i2cms_pkg::CTL_DISABLE;
          end else begin
            res_nxt.buffer_irq  = i2cms_pkg::CTL_ENABLE;
          end
        end else if (req_r.status_flags[2]) begin
          // Byte transfer done
          final_stop_nxt = 1'b1;
          if (rd_phase) begin
            wa_en   = pos_in(p);
            wa_addr = p[IW-1:0];
            wa_data = req_r.rx_first;
            wb_en   = pos_in(p + 8'd1);
            wb_addr = IW'(p + 8'd1);
            wb_data = req_r.rx_second;
            res_nxt.bus_command = i2cms_pkg::CMD_STOP;
            if (byte_count_r > 7'd2) begin
              res_nxt.ack_control = i2cms_pkg::CTL_DISABLE;
              res_nxt.buffer_irq  = i2cms_pkg::CTL_ENABLE;
              p = p + 8'd2;
            end else begin
              p = p + 8'd3;
            end
          end else if (subaddr_done_r || is_writing_r) begin
            res_nxt.bus_command = i2cms_pkg::CMD_STOP;
            p = p + 8'd1;
          end else begin
            res_nxt.bus_command = i2cms_pkg::CMD_START;
            subaddr_done_nxt    = 1'b1;
          end
        end else if (req_r.status_flags[3]) begin
          // Receive buffer not empty
          wa_en   = pos_in(p);
          wa_addr = p[IW-1:0];
          wa_data = req_r.rx_first;
          p = p + 8'd1;
          if (bc == pos_sx(p) + 10'sd3) begin
            res_nxt.buffer_irq = i2cms_pkg::CTL_DISABLE;
          end
          if (bc == pos_sx(p)) begin
            p = p + 8'd1;
          end
        end else if (req_r.status_flags[4]) begin
          // Transmit buffer empty
          res_nxt.bus_command = i2cms_pkg::CMD_DATA_WR;
          if (p != i2cms_pkg::POS_SUBADDR) begin
            if (bc == pos_sx(p) + 10'sd1) begin
              res_nxt.buffer_irq = i2cms_pkg::CTL_DISABLE;
            end
            ob_mem_nxt = pos_in(p);
            rd_addr    = p[IW-1:0];
            p = p + 8'd1;
          end else begin
            p = p + 8'd1;
            if (is_reading_r || byte_count_r == 7'd0) begin
              res_nxt.buffer_irq = i2cms_pkg::CTL_DISABLE;
            end
            res_nxt.out_byte = sub_register_r;
          end
        end
        position_nxt = p;
        // End of transfer
        if (pos_sx(p) == bc + 10'sd1) begin
          subaddr_done_nxt = 1'b0;
          if (final_stop_nxt) begin
            res_nxt.irqs_control = i2cms_pkg::CTL_DISABLE;
            irqs_en_nxt          = 1'b0;
          end
          res_nxt.done_res = busy_nxt;
          busy_nxt         = 1'b0;
        end
      end
      default: begin
      end
    endcase

    res_nxt.busy_res = busy_nxt;
    res_nxt.error    = error_nxt;
    bank_nxt         = rd_addr[0];
  end

  // Route write requests to the even and odd banks
  always_comb begin
    we0   = 1'b0;
    we1   = 1'b0;
    wrow0 = '0;
    wrow1 = '0;
    wdat0 = '0;
    wdat1 = '0;
    if (wa_en) begin
      if (wa_addr[0]) begin
        we1 = 1'b1; wrow1 = wa_addr[IW-1:1]; wdat1 = wa_data;
      end else begin
        we0 = 1'b1; wrow0 = wa_addr[IW-1:1]; wdat0 = wa_data;
      end
    end
    if (wb_en) begin
      if (wb_addr[0]) begin
        we1 = 1'b1; wrow1 = wb_addr[IW-1:1]; wdat1 = wb_data;
      end else begin
        we0 = 1'b1; wrow0 = wb_addr[IW-1:1]; wdat0 = wb_data;
      end
    end
  end

  // Buffer banks: one write and one registered read each
  always_ff @(posedge clk) begin
    if (fire && we0) begin
      bank0_mem[wrow0] <= wdat0;
    end
    if (fire && we1) begin
      bank1_mem[wrow1] <= wdat1;
    end
    if (fire) begin
      bank0_q_r <= bank0_mem[rd_addr[IW-1:1]];
      bank1_q_r <= bank1_mem[rd_addr[IW-1:1]];
    end
  end

  // Commit state on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_byte_r    <= '0;
      sub_register_r <= '0;
      byte_count_r   <= '0;
      is_reading_r   <= 1'b0;
      is_writing_r   <= 1'b0;
      busy_r         <= 1'b0;
      error_r        <= 1'b0;
      subaddr_done_r <= 1'b0;
      final_stop_r   <= 1'b0;
      position_r     <= '0;
      irqs_en_r      <= 1'b0;
    end else if (fire) begin
      addr_byte_r    <= addr_byte_nxt;
      sub_register_r <= sub_register_nxt;
      byte_count_r   <= byte_count_nxt;
      is_reading_r   <= is_reading_nxt;
      is_writing_r   <= is_writing_nxt;
      busy_r         <= busy_nxt;
      error_r        <= error_nxt;
      subaddr_done_r <= subaddr_done_nxt;
      final_stop_r   <= final_stop_nxt;
      position_r     <= position_nxt;
      irqs_en_r      <= irqs_en_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r    <= res_nxt;
      ob_mem_r <= ob_mem_nxt;
      rd_mem_r <= rd_mem_nxt;
      bank_r   <= bank_nxt;
    end
  end

  // Pick the buffer byte from the addressed bank
  assign rd_byte    = bank_r ? bank1_q_r : bank0_q_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       (rd_mem_r ? rd_byte : 8'h00),
                       res_r.accepted,
                       res_r.done_res,
                       res_r.error,
                       res_r.busy_res,
                       res_r.irqs_control,
                       res_r.buffer_irq,
                       res_r.ack_next_position,
                       res_r.ack_control,
                       (ob_mem_r ? rd_byte : res_r.out_byte),
                       res_r.bus_command};

`ifndef SYNTHESIS
  // An accepted begin leaves the block busy with the error flag cleared
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |-> out_tdata[18] && !out_tdata[19])
    else $error("accepted begin without busy set");

  // A completed transfer is no longer busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> !out_tdata[18])
    else $error("done reported while busy");

  // An empty result register never blocks the input side
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // A processed item always reaches the result register
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("processed item lost");
`endif

endmodule
